// ===== design/rcf_pkg.sv =====
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types, status codes and Q16.16 saturating arithmetic for the
// face mass flux pipeline.
// ----------------------------------------------------------------------------
package rcf_pkg;

    localparam int FX_W = 32;
    localparam logic signed [31:0] FX_ONE = 32'sd65536;
    localparam logic [30:0] DENSITY_RESET = 31'd65536;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RESP_NEG = 2'd1;
    localparam logic [1:0] ST_COEF_NEG = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } t_fx;

    function automatic t_fx fx_sat(input logic signed [48:0] v, input int vw);
        logic signed [48:0] vmax;
        logic signed [48:0] vmin;
        t_fx                r;
        vmax = (49'sd1 <<< (vw - 1)) - 49'sd1;
        vmin = -vmax - 49'sd1;
        if (v > vmax) begin
            r.ovf = 1'b1;
            r.val = vmax[31:0];
        end else if (v < vmin) begin
            r.ovf = 1'b1;
            r.val = vmin[31:0];
        end else begin
            r.ovf = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    function automatic t_fx fx_add(input logic signed [31:0] a,
                                   input logic signed [31:0] b, input int vw);
        return fx_sat(49'(a) + 49'(b), vw);
    endfunction

    function automatic t_fx fx_sub(input logic signed [31:0] a,
                                   input logic signed [31:0] b, input int vw);
        return fx_sat(49'(a) - 49'(b), vw);
    endfunction

    // exact product, rounded to nearest with ties away from zero
    function automatic t_fx fx_mul(input logic signed [31:0] a,
                                   input logic signed [31:0] b, input int vw);
        logic signed [63:0] p;
        logic [63:0]        mag;
        logic [63:0]        rnd;
        logic signed [48:0] rv;
        p   = 64'(a) * 64'(b);
        mag = p[63] ? 64'(-p) : 64'(p);
        rnd = (mag + 64'd32768) >> 16;
        rv  = $signed(rnd[48:0]);
        return fx_sat(p[63] ? -rv : rv, vw);
    endfunction

endpackage

// ===== design/rhie_chow_face_mass_flux.sv =====
// ----------------------------------------------------------------------------
// rhie_chow_face_mass_flux
// Rhie-Chow face mass flux and pressure response, one face per unstalled cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one request carries the geometry and
//   owner/neighbor cell values of one internal face. Output channel
//   (o_valid / i_stall): one result per request, in order: mass flux,
//   pressure response (both density scaled, Q16.16) and a status code.
//   Config channel (i_cfg_valid / o_cfg_ready): writes the density; always
//   ready, to be written only while no request is in flight.
//   Throughput is one request per cycle while the receiver does not
//   stall; the eight pipeline stages each hold one multiply level with
//   its rounding and saturation.
//   When the receiver stalls while a result is shown, the whole pipeline
//   holds and o_stall rises in the same cycle; nothing is lost or repeated.
//   Synchronous reset empties the pipeline and sets the density to 1.0.
//   A status other than ok forces both numeric results to zero.
// ----------------------------------------------------------------------------
module rhie_chow_face_mass_flux #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [63:0]        i_area_vector,
    input  logic [63:0]        i_center_offset,
    input  logic [63:0]        i_geometry_terms,
    input  logic [63:0]        i_owner_velocity,
    input  logic [63:0]        i_neighbor_velocity,
    input  logic [63:0]        i_owner_gradient,
    input  logic [63:0]        i_neighbor_gradient,
    input  logic [63:0]        i_owner_response,
    input  logic [63:0]        i_neighbor_response,
    input  logic [63:0]        i_cell_pressures,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_face_flux,
    output logic signed [31:0] o_press_resp,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [30:0]        i_cfg_data
);

    localparam int VW = VALUE_WIDTH;

    logic        en;
    logic [7:0]  r_vld;
    logic [30:0] r_density;
    logic signed [31:0] rho;

    assign en          = ~(r_vld[7] & i_stall);
    assign o_stall     = ~en;
    assign o_valid     = r_vld[7];
    assign o_cfg_ready = 1'b1;
    assign rho         = $signed({1'b0, r_density});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_density <= rcf_pkg::DENSITY_RESET;
        end else begin
            if (en) begin
                r_vld <= {r_vld[6:0], i_valid};
            end
            if (i_cfg_valid) begin
                r_density <= i_cfg_data;
            end
        end
    end

    // ---------------- stage 1 ----------------
    logic signed [31:0] ax, ay, dx, dy, lam, inv, ou, ov, nu, nv;
    logic signed [31:0] ogx, ogy, ngx, ngy, oru, orv, nru, nrv, po, pn;
    assign ax  = i_area_vector[31:0];       assign ay  = i_area_vector[63:32];
    assign dx  = i_center_offset[31:0];     assign dy  = i_center_offset[63:32];
    assign lam = i_geometry_terms[31:0];    assign inv = i_geometry_terms[63:32];
    assign ou  = i_owner_velocity[31:0];    assign ov  = i_owner_velocity[63:32];
    assign nu  = i_neighbor_velocity[31:0]; assign nv  = i_neighbor_velocity[63:32];
    assign ogx = i_owner_gradient[31:0];    assign ogy = i_owner_gradient[63:32];
    assign ngx = i_neighbor_gradient[31:0]; assign ngy = i_neighbor_gradient[63:32];
    assign oru = i_owner_response[31:0];    assign orv = i_owner_response[63:32];
    assign nru = i_neighbor_response[31:0]; assign nrv = i_neighbor_response[63:32];
    assign po  = i_cell_pressures[31:0];    assign pn  = i_cell_pressures[63:32];

    rcf_pkg::t_fx n1_ow, n1_jump, n1_q1, n1_q2, n1_q3, n1_q4;
    logic n1_rneg;
    always_comb begin
        n1_ow   = rcf_pkg::fx_sub(rcf_pkg::FX_ONE, lam, VW);
        n1_jump = rcf_pkg::fx_sub(pn, po, VW);
        n1_q1   = rcf_pkg::fx_mul(oru, ogx, VW);
        n1_q2   = rcf_pkg::fx_mul(orv, ogy, VW);
        n1_q3   = rcf_pkg::fx_mul(nru, ngx, VW);
        n1_q4   = rcf_pkg::fx_mul(nrv, ngy, VW);
        n1_rneg = (oru <= 0) || (orv <= 0) || (nru <= 0) || (nrv <= 0);
    end

    logic signed [31:0] r1_ow, r1_lam, r1_jump, r1_q1, r1_q2, r1_q3, r1_q4;
    logic signed [31:0] r1_ou, r1_ov, r1_nu, r1_nv, r1_oru, r1_orv, r1_nru, r1_nrv;
    logic signed [31:0] r1_ogx, r1_ogy, r1_ngx, r1_ngy, r1_ax, r1_ay, r1_dx, r1_dy;
    logic signed [31:0] r1_inv;
    logic r1_rneg, r1_ovf;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ow <= n1_ow.val;  r1_lam <= lam;  r1_jump <= n1_jump.val;
            r1_q1 <= n1_q1.val;  r1_q2 <= n1_q2.val;
            r1_q3 <= n1_q3.val;  r1_q4 <= n1_q4.val;
            r1_ou <= ou;  r1_ov <= ov;  r1_nu <= nu;  r1_nv <= nv;
            r1_oru <= oru;  r1_orv <= orv;  r1_nru <= nru;  r1_nrv <= nrv;
            r1_ogx <= ogx;  r1_ogy <= ogy;  r1_ngx <= ngx;  r1_ngy <= ngy;
            r1_ax <= ax;  r1_ay <= ay;  r1_dx <= dx;  r1_dy <= dy;  r1_inv <= inv;
            r1_rneg <= n1_rneg;
            r1_ovf  <= n1_ow.ovf | n1_jump.ovf | n1_q1.ovf | n1_q2.ovf
                     | n1_q3.ovf | n1_q4.ovf;
        end
    end

    // ---------------- stage 2 ----------------
    rcf_pkg::t_fx n2_opx, n2_opy, n2_npx, n2_npy;
    rcf_pkg::t_fx n2_b1, n2_b2, n2_b3, n2_b4, n2_g1, n2_g2, n2_g3, n2_g4;
    rcf_pkg::t_fx n2_e1, n2_e2, n2_e3, n2_e4;
    always_comb begin
        n2_opx = rcf_pkg::fx_add(r1_ou, r1_q1, VW);
        n2_opy = rcf_pkg::fx_add(r1_ov, r1_q2, VW);
        n2_npx = rcf_pkg::fx_add(r1_nu, r1_q3, VW);
        n2_npy = rcf_pkg::fx_add(r1_nv, r1_q4, VW);
        n2_b1  = rcf_pkg::fx_mul(r1_ow, r1_oru, VW);
        n2_b2  = rcf_pkg::fx_mul(r1_lam, r1_nru, VW);
        n2_b3  = rcf_pkg::fx_mul(r1_ow, r1_orv, VW);
        n2_b4  = rcf_pkg::fx_mul(r1_lam, r1_nrv, VW);
        n2_g1  = rcf_pkg::fx_mul(r1_ow, r1_ogx, VW);
        n2_g2  = rcf_pkg::fx_mul(r1_lam, r1_ngx, VW);
        n2_g3  = rcf_pkg::fx_mul(r1_ow, r1_ogy, VW);
        n2_g4  = rcf_pkg::fx_mul(r1_lam, r1_ngy, VW);
        n2_e1  = rcf_pkg::fx_mul(r1_ow, n2_opx.val, VW);
        n2_e2  = rcf_pkg::fx_mul(r1_lam, n2_npx.val, VW);
        n2_e3  = rcf_pkg::fx_mul(r1_ow, n2_opy.val, VW);
        n2_e4  = rcf_pkg::fx_mul(r1_lam, n2_npy.val, VW);
    end

    logic signed [31:0] r2_b1, r2_b2, r2_b3, r2_b4, r2_g1, r2_g2, r2_g3, r2_g4;
    logic signed [31:0] r2_e1, r2_e2, r2_e3, r2_e4;
    logic signed [31:0] r2_ax, r2_ay, r2_dx, r2_dy, r2_inv, r2_jump;
    logic r2_rneg, r2_ovf;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_b1 <= n2_b1.val;  r2_b2 <= n2_b2.val;
            r2_b3 <= n2_b3.val;  r2_b4 <= n2_b4.val;
            r2_g1 <= n2_g1.val;  r2_g2 <= n2_g2.val;
            r2_g3 <= n2_g3.val;  r2_g4 <= n2_g4.val;
            r2_e1 <= n2_e1.val;  r2_e2 <= n2_e2.val;
            r2_e3 <= n2_e3.val;  r2_e4 <= n2_e4.val;
            r2_ax <= r1_ax;  r2_ay <= r1_ay;  r2_dx <= r1_dx;  r2_dy <= r1_dy;
            r2_inv <= r1_inv;  r2_jump <= r1_jump;  r2_rneg <= r1_rneg;
            r2_ovf <= r1_ovf | n2_opx.ovf | n2_opy.ovf | n2_npx.ovf | n2_npy.ovf
                    | n2_b1.ovf | n2_b2.ovf | n2_b3.ovf | n2_b4.ovf
                    | n2_g1.ovf | n2_g2.ovf | n2_g3.ovf | n2_g4.ovf
                    | n2_e1.ovf | n2_e2.ovf | n2_e3.ovf | n2_e4.ovf;
        end
    end

    // ---------------- stage 3 ----------------
    rcf_pkg::t_fx n3_fu, n3_fv, n3_fgx, n3_fgy, n3_fpx, n3_fpy;
    rcf_pkg::t_fx n3_rax, n3_ray, n3_h1, n3_h2;
    always_comb begin
        n3_fu  = rcf_pkg::fx_add(r2_b1, r2_b2, VW);
        n3_fv  = rcf_pkg::fx_add(r2_b3, r2_b4, VW);
        n3_fgx = rcf_pkg::fx_add(r2_g1, r2_g2, VW);
        n3_fgy = rcf_pkg::fx_add(r2_g3, r2_g4, VW);
        n3_fpx = rcf_pkg::fx_add(r2_e1, r2_e2, VW);
        n3_fpy = rcf_pkg::fx_add(r2_e3, r2_e4, VW);
        n3_rax = rcf_pkg::fx_mul(n3_fu.val, r2_ax, VW);
        n3_ray = rcf_pkg::fx_mul(n3_fv.val, r2_ay, VW);
        n3_h1  = rcf_pkg::fx_mul(n3_fpx.val, r2_ax, VW);
        n3_h2  = rcf_pkg::fx_mul(n3_fpy.val, r2_ay, VW);
    end

    logic signed [31:0] r3_rax, r3_ray, r3_fgx, r3_fgy, r3_h1, r3_h2;
    logic signed [31:0] r3_ax, r3_ay, r3_dx, r3_dy, r3_inv, r3_jump;
    logic r3_rneg, r3_ovf;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_rax <= n3_rax.val;  r3_ray <= n3_ray.val;
            r3_fgx <= n3_fgx.val;  r3_fgy <= n3_fgy.val;
            r3_h1  <= n3_h1.val;   r3_h2  <= n3_h2.val;
            r3_ax <= r2_ax;  r3_ay <= r2_ay;  r3_dx <= r2_dx;  r3_dy <= r2_dy;
            r3_inv <= r2_inv;  r3_jump <= r2_jump;  r3_rneg <= r2_rneg;
            r3_ovf <= r2_ovf | n3_fu.ovf | n3_fv.ovf | n3_fgx.ovf | n3_fgy.ovf
                    | n3_fpx.ovf | n3_fpy.ovf | n3_rax.ovf | n3_ray.ovf
                    | n3_h1.ovf | n3_h2.ovf;
        end
    end

    // ---------------- stage 4 ----------------
    rcf_pkg::t_fx n4_c1, n4_c2;
    always_comb begin
        n4_c1 = rcf_pkg::fx_mul(r3_ax, r3_rax, VW);
        n4_c2 = rcf_pkg::fx_mul(r3_ay, r3_ray, VW);
    end

    logic signed [31:0] r4_c1, r4_c2, r4_rax, r4_ray, r4_fgx, r4_fgy, r4_h1, r4_h2;
    logic signed [31:0] r4_dx, r4_dy, r4_inv, r4_jump;
    logic r4_rneg, r4_ovf;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_c1 <= n4_c1.val;  r4_c2 <= n4_c2.val;
            r4_rax <= r3_rax;  r4_ray <= r3_ray;  r4_fgx <= r3_fgx;  r4_fgy <= r3_fgy;
            r4_h1 <= r3_h1;  r4_h2 <= r3_h2;  r4_dx <= r3_dx;  r4_dy <= r3_dy;
            r4_inv <= r3_inv;  r4_jump <= r3_jump;  r4_rneg <= r3_rneg;
            r4_ovf <= r3_ovf | n4_c1.ovf | n4_c2.ovf;
        end
    end

    // ---------------- stage 5 ----------------
    rcf_pkg::t_fx n5_s, n5_coef;
    always_comb begin
        n5_s    = rcf_pkg::fx_add(r4_c1, r4_c2, VW);
        n5_coef = rcf_pkg::fx_mul(n5_s.val, r4_inv, VW);
    end

    logic signed [31:0] r5_coef, r5_rax, r5_ray, r5_fgx, r5_fgy, r5_h1, r5_h2;
    logic signed [31:0] r5_dx, r5_dy, r5_jump;
    logic r5_rneg, r5_ovf;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_coef <= n5_coef.val;
            r5_rax <= r4_rax;  r5_ray <= r4_ray;  r5_fgx <= r4_fgx;  r5_fgy <= r4_fgy;
            r5_h1 <= r4_h1;  r5_h2 <= r4_h2;  r5_dx <= r4_dx;  r5_dy <= r4_dy;
            r5_jump <= r4_jump;  r5_rneg <= r4_rneg;
            r5_ovf <= r4_ovf | n5_s.ovf | n5_coef.ovf;
        end
    end

    // ---------------- stage 6 ----------------
    rcf_pkg::t_fx n6_presp, n6_cdx, n6_cdy, n6_cj;
    always_comb begin
        n6_presp = rcf_pkg::fx_mul(rho, r5_coef, VW);
        n6_cdx   = rcf_pkg::fx_mul(r5_coef, r5_dx, VW);
        n6_cdy   = rcf_pkg::fx_mul(r5_coef, r5_dy, VW);
        n6_cj    = rcf_pkg::fx_mul(r5_coef, r5_jump, VW);
    end

    logic signed [31:0] r6_presp, r6_coef, r6_cdx, r6_cdy, r6_cj;
    logic signed [31:0] r6_rax, r6_ray, r6_fgx, r6_fgy, r6_h1, r6_h2;
    logic r6_rneg, r6_ovf;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_presp <= n6_presp.val;  r6_coef <= r5_coef;
            r6_cdx <= n6_cdx.val;  r6_cdy <= n6_cdy.val;  r6_cj <= n6_cj.val;
            r6_rax <= r5_rax;  r6_ray <= r5_ray;  r6_fgx <= r5_fgx;  r6_fgy <= r5_fgy;
            r6_h1 <= r5_h1;  r6_h2 <= r5_h2;  r6_rneg <= r5_rneg;
            r6_ovf <= r5_ovf | n6_presp.ovf | n6_cdx.ovf | n6_cdy.ovf | n6_cj.ovf;
        end
    end

    // ---------------- stage 7 ----------------
    rcf_pkg::t_fx n7_tx, n7_ty, n7_t1, n7_t2, n7_u, n7_v;
    always_comb begin
        n7_tx = rcf_pkg::fx_sub(r6_rax, r6_cdx, VW);
        n7_ty = rcf_pkg::fx_sub(r6_ray, r6_cdy, VW);
        n7_t1 = rcf_pkg::fx_mul(r6_fgx, n7_tx.val, VW);
        n7_t2 = rcf_pkg::fx_mul(r6_fgy, n7_ty.val, VW);
        n7_u  = rcf_pkg::fx_add(r6_h1, r6_h2, VW);
        n7_v  = rcf_pkg::fx_sub(n7_u.val, r6_cj, VW);
    end

    logic signed [31:0] r7_t1, r7_t2, r7_v, r7_presp, r7_coef;
    logic r7_rneg, r7_ovf;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_t1 <= n7_t1.val;  r7_t2 <= n7_t2.val;  r7_v <= n7_v.val;
            r7_presp <= r6_presp;  r7_coef <= r6_coef;  r7_rneg <= r6_rneg;
            r7_ovf <= r6_ovf | n7_tx.ovf | n7_ty.ovf | n7_t1.ovf | n7_t2.ovf
                    | n7_u.ovf | n7_v.ovf;
        end
    end

    // ---------------- stage 8 ----------------
    rcf_pkg::t_fx n8_w, n8_f0, n8_mf;
    logic [1:0]   n8_status;
    always_comb begin
        n8_w  = rcf_pkg::fx_add(r7_t1, r7_t2, VW);
        n8_f0 = rcf_pkg::fx_sub(r7_v, n8_w.val, VW);
        n8_mf = rcf_pkg::fx_mul(rho, n8_f0.val, VW);
        priority if (r7_rneg) begin
            n8_status = rcf_pkg::ST_RESP_NEG;
        end else if (r7_coef <= 0 || r7_presp <= 0) begin
            n8_status = rcf_pkg::ST_COEF_NEG;
        end else if (r7_ovf | n8_w.ovf | n8_f0.ovf | n8_mf.ovf) begin
            n8_status = rcf_pkg::ST_OVERFLOW;
        end else begin
            n8_status = rcf_pkg::ST_OK;
        end
    end

    logic signed [31:0] r8_mflux, r8_presp;
    logic [1:0]         r8_status;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_status <= n8_status;
            r8_mflux  <= (n8_status == rcf_pkg::ST_OK) ? n8_mf.val : 32'sd0;
            r8_presp  <= (n8_status == rcf_pkg::ST_OK) ? r7_presp : 32'sd0;
        end
    end

    assign o_face_flux  = r8_mflux;
    assign o_press_resp = r8_presp;
    assign o_status     = r8_status;

endmodule

// ===== design/rcf_checker.sv =====
// ----------------------------------------------------------------------------
// rcf_checker
// Port-level checks for the face mass flux block, bound to the top level.
// ----------------------------------------------------------------------------
module rcf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_face_flux,
    input logic signed [31:0] o_press_resp,
    input logic [1:0]         o_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_face_flux) && $stable(o_status))
        else $error("stalled result changed");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != rcf_pkg::ST_OK |->
            o_face_flux == 0 && o_press_resp == 0)
        else $error("rejected face carries nonzero results");

    a_ok_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == rcf_pkg::ST_OK |-> o_press_resp > 0)
        else $error("accepted face with non-positive pressure response");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

endmodule

bind rhie_chow_face_mass_flux rcf_checker u_rcf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_face_flux  (o_face_flux),
    .o_press_resp (o_press_resp),
    .o_status     (o_status)
);
